FILE: design/nms_pkg.sv
// shared types, codes and defaults of the nested motion sequencer
`default_nettype none
package nms_pkg;

	localparam int STACK_DEPTH_DEF = 5;
	localparam int ENTRY_WORDS_DEF = 256;
	localparam int MOVE_WORDS_DEF  = 256;

	localparam logic [15:0] TPU_RESET = 16'd1000;

	// item function codes, code three is unused
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_ENTRY = 2'd1;
	localparam logic [1:0] FUNC_MOVE  = 2'd2;

	// entry kinds, anything from end mark up climbs
	localparam logic [1:0] KIND_MOVES = 2'd0;
	localparam logic [1:0] KIND_SUB   = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] target;
	} entry_t;

	typedef struct packed {
		logic signed [8:0]  angle_c;
		logic signed [8:0]  angle_b;
		logic signed [8:0]  angle_a;
		logic [7:0]         speed;
		logic signed [10:0] time_u;
	} move_t;

	typedef struct packed {
		logic signed [8:0] angle_a;
		logic signed [8:0] angle_b;
		logic signed [8:0] angle_c;
		logic [7:0]        speed;
	} result_t;

	typedef struct packed {
		logic       en;
		logic [7:0] base;
		logic [7:0] pos;
	} rd_req_t;

	typedef struct packed {
		logic       entry_en;
		logic       move_en;
		logic [7:0] addr;
		entry_t     entry;
		move_t      move;
	} wr_req_t;

endpackage
`default_nettype wire

FILE: design/nms_tables.sv
// entry and move table memories with address wrap and registered reads
`default_nettype none
module nms_tables #(
	parameter int ENTRY_WORDS = 256,
	parameter int MOVE_WORDS  = 256
) (
	input  wire logic            clk,
	input  wire nms_pkg::wr_req_t wr_req,
	input  wire nms_pkg::rd_req_t rd_req,
	output nms_pkg::entry_t       entry_rd,
	output nms_pkg::move_t        move_rd
);
	import nms_pkg::*;

	localparam int EAW = $clog2(ENTRY_WORDS);
	localparam int MAW = $clog2(MOVE_WORDS);

	entry_t entry_mem [ENTRY_WORDS];
	move_t  move_mem  [MOVE_WORDS];

	// residue tables for 8-bit values, built at elaboration
	logic [EAW-1:0] emod_tab [256];
	logic [MAW-1:0] mmod_tab [256];

	for (genvar gi = 0; gi < 256; gi++) begin : g_mod
		assign emod_tab[gi] = EAW'(gi % ENTRY_WORDS);
		assign mmod_tab[gi] = MAW'(gi % MOVE_WORDS);
	end

	logic [EAW:0]   esum;
	logic [MAW:0]   msum;
	logic [EAW-1:0] erd_addr;
	logic [MAW-1:0] mrd_addr;

	// both residues are below the size, so one subtract finishes the wrap
	always_comb begin
		esum = {1'b0, emod_tab[rd_req.base]} + {1'b0, emod_tab[rd_req.pos]};
		msum = {1'b0, mmod_tab[rd_req.base]} + {1'b0, mmod_tab[rd_req.pos]};
		if (esum >= (EAW+1)'(ENTRY_WORDS)) begin
			erd_addr = EAW'(esum - (EAW+1)'(ENTRY_WORDS));
		end else begin
			erd_addr = esum[EAW-1:0];
		end
		if (msum >= (MAW+1)'(MOVE_WORDS)) begin
			mrd_addr = MAW'(msum - (MAW+1)'(MOVE_WORDS));
		end else begin
			mrd_addr = msum[MAW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_req.entry_en) begin
			entry_mem[emod_tab[wr_req.addr]] <= wr_req.entry;
		end
		if (rd_req.en) begin
			entry_rd <= entry_mem[erd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_req.move_en) begin
			move_mem[mmod_tab[wr_req.addr]] <= wr_req.move;
		end
		if (rd_req.en) begin
			move_rd <= move_mem[mrd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: design/nms_stack.sv
// level stack, exit time and step decision of the sequencer
`default_nettype none
module nms_stack #(
	parameter int STACK_DEPTH = 5
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            tick_go,
	input  wire logic [31:0]     now,
	input  wire logic [15:0]     tpu,
	input  wire nms_pkg::entry_t entry_rd,
	input  wire nms_pkg::move_t  move_rd,
	output nms_pkg::rd_req_t     rd_req,
	output logic                 busy,
	output logic                 res_valid,
	output nms_pkg::result_t     res
);
	import nms_pkg::*;

	localparam int DW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [DW-1:0] LAST = DW'(STACK_DEPTH - 1);

	logic          kind_q [STACK_DEPTH];
	logic [7:0]    base_q [STACK_DEPTH];
	logic [7:0]    pos_q  [STACK_DEPTH];
	logic [DW-1:0] depth_q;
	logic [31:0]   exit_q;

	logic        step_s1;
	logic [31:0] now_s1;

	logic          do_climb;
	logic          do_push;
	logic          do_adv;
	logic          do_emit;
	logic [DW-1:0] up_lv;
	logic [DW-1:0] dn_lv;
	logic [25:0]   span;

	assign rd_req.en   = tick_go && (now > exit_q);
	assign rd_req.base = base_q[depth_q];
	assign rd_req.pos  = pos_q[depth_q];
	assign busy        = step_s1;

	assign up_lv = depth_q + 1'b1;
	assign dn_lv = depth_q - 1'b1;
	assign span  = move_rd.time_u[9:0] * tpu;

	always_comb begin
		do_climb = 1'b0;
		do_push  = 1'b0;
		do_adv   = 1'b0;
		do_emit  = 1'b0;
		if (step_s1) begin
			if (kind_q[depth_q]) begin
				if (entry_rd.kind >= KIND_END) begin
					do_climb = 1'b1;
				end else if (depth_q < LAST) begin
					do_push = 1'b1;
				end else begin
					// stack full: skip the child
					do_adv = 1'b1;
				end
			end else if (move_rd.time_u[10]) begin
				do_climb = 1'b1;
			end else begin
				do_emit = 1'b1;
				do_adv  = 1'b1;
			end
		end
	end

	assign res_valid   = do_emit;
	assign res.angle_a = move_rd.angle_a;
	assign res.angle_b = move_rd.angle_b;
	assign res.angle_c = move_rd.angle_c;
	assign res.speed   = move_rd.speed;

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			now_s1 <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STACK_DEPTH; i++) begin
				kind_q[i] <= (i == 0);
				base_q[i] <= '0;
				pos_q[i]  <= '0;
			end
			depth_q <= '0;
			exit_q  <= '0;
			step_s1 <= 1'b0;
		end else begin
			step_s1 <= rd_req.en;
			if (do_climb) begin
				if (depth_q == '0) begin
					pos_q[0] <= '0;
				end else begin
					depth_q      <= dn_lv;
					pos_q[dn_lv] <= pos_q[dn_lv] + 8'd1;
				end
			end
			if (do_push) begin
				depth_q       <= up_lv;
				kind_q[up_lv] <= (entry_rd.kind == KIND_SUB);
				base_q[up_lv] <= entry_rd.target;
				pos_q[up_lv]  <= '0;
			end
			if (do_adv) begin
				pos_q[depth_q] <= pos_q[depth_q] + 8'd1;
			end
			if (do_emit) begin
				exit_q <= now_s1 + 32'(span);
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/nms_out_q.sv
// two-entry result queue in front of the output channel
`default_nettype none
module nms_out_q (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire nms_pkg::result_t push_data,
	input  wire logic             pop,
	output logic                  head_valid,
	output logic                  full,
	output nms_pkg::result_t      head
);
	import nms_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       take;

	assign head_valid = (count_q != 2'd0);
	assign full       = (count_q == 2'd2);
	assign head       = slot_q[rd_ptr_q];
	assign take       = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/nested_motion_sequencer_core.sv
// a stepping tick reads the tables at the accepting edge and updates the stack at the next
// its move shows at the output after the edge that follows acceptance; writes and idle ticks do not stall the input
// no new item is taken while a stepping tick is still updating the stack
// a two-entry result queue lets ticks continue while a move waits on a stalled output, until the queue is full
// reset clears stack, exit time and queue, sets ticks_per_unit to 1000; tables are not cleared
`default_nettype none
module nested_motion_sequencer_core #(
	parameter int STACK_DEPTH = nms_pkg::STACK_DEPTH_DEF,
	parameter int ENTRY_WORDS = nms_pkg::ENTRY_WORDS_DEF,
	parameter int MOVE_WORDS  = nms_pkg::MOVE_WORDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        func,
	input  wire logic [7:0]        addr,
	input  wire logic [1:0]        entry_kind,
	input  wire logic [7:0]        entry_target,
	input  wire logic signed [10:0] move_time,
	input  wire logic [7:0]        move_speed,
	input  wire logic signed [8:0] angle_a,
	input  wire logic signed [8:0] angle_b,
	input  wire logic signed [8:0] angle_c,
	input  wire logic [31:0]       now,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [8:0]      out_angle_a,
	output logic signed [8:0]      out_angle_b,
	output logic signed [8:0]      out_angle_c,
	output logic [7:0]             out_speed,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [15:0]       ticks_per_unit
);
	import nms_pkg::*;

	logic    in_beat;
	logic    tick_go;
	logic    busy;
	logic    q_full;
	logic    res_valid;
	logic [15:0] tpu_q;
	wr_req_t wr_req;
	rd_req_t rd_req;
	entry_t  entry_rd;
	move_t   move_rd;
	result_t res;
	result_t head;

	assign in_stall  = busy || q_full;
	assign in_beat   = in_valid && !in_stall;
	assign tick_go   = in_beat && (func == FUNC_TICK);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tpu_q <= ticks_per_unit;
		end
	end

	assign wr_req.entry_en      = in_beat && (func == FUNC_ENTRY);
	assign wr_req.move_en       = in_beat && (func == FUNC_MOVE);
	assign wr_req.addr          = addr;
	assign wr_req.entry.kind    = entry_kind;
	assign wr_req.entry.target  = entry_target;
	assign wr_req.move.angle_c  = angle_c;
	assign wr_req.move.angle_b  = angle_b;
	assign wr_req.move.angle_a  = angle_a;
	assign wr_req.move.speed    = move_speed;
	assign wr_req.move.time_u   = move_time;

	nms_tables #(
		.ENTRY_WORDS(ENTRY_WORDS),
		.MOVE_WORDS (MOVE_WORDS)
	) u_tables (
		.clk     (clk),
		.wr_req  (wr_req),
		.rd_req  (rd_req),
		.entry_rd(entry_rd),
		.move_rd (move_rd)
	);

	nms_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick_go  (tick_go),
		.now      (now),
		.tpu      (tpu_q),
		.entry_rd (entry_rd),
		.move_rd  (move_rd),
		.rd_req   (rd_req),
		.busy     (busy),
		.res_valid(res_valid),
		.res      (res)
	);

	nms_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (!out_stall),
		.head_valid(out_valid),
		.full      (q_full),
		.head      (head)
	);

	assign out_angle_a = head.angle_a;
	assign out_angle_b = head.angle_b;
	assign out_angle_c = head.angle_c;
	assign out_speed   = head.speed;

endmodule
`default_nettype wire

FILE: verif/tb.sv
// self-checking testbench for the nested motion sequencer core
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nms_pkg::*;

	localparam int LEVELS = STACK_DEPTH_DEF;
	localparam int STUCK_LIMIT = 3000;
	localparam int PHASE_ITEMS = 90;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic [7:0]         addr;
		logic [1:0]         entry_kind;
		logic [7:0]         entry_target;
		logic signed [10:0] move_time;
		logic [7:0]         move_speed;
		logic signed [8:0]  angle_a;
		logic signed [8:0]  angle_b;
		logic signed [8:0]  angle_c;
		logic [31:0]        now;
	} stim_t;

	class move_scoreboard;
		logic [15:0] units;
		bit          level_sub [LEVELS];
		logic [7:0]  level_base [LEVELS];
		logic [7:0]  level_pos [LEVELS];
		int unsigned depth;
		logic [31:0] exit_time;
		entry_t      entries [256];
		move_t       moves [256];
		result_t     expected_moves [$];
		int          errors;

		function new();
			units = TPU_RESET;
			foreach (level_sub[i]) begin
				level_sub[i] = 1'b0;
				level_base[i] = '0;
				level_pos[i] = '0;
			end
			level_sub[0] = 1'b1;
			depth = 0;
			exit_time = '0;
			errors = 0;
		endfunction

		// leave the current level, the root restarts from its top
		function void climb();
			if (depth == 0) begin
				level_pos[0] = '0;
			end else begin
				depth--;
				level_pos[depth] = level_pos[depth] + 8'd1;
			end
		endfunction

		function void note_item(stim_t s);
			int unsigned lv;
			logic [7:0]  where;
			entry_t      e;
			move_t       m;
			if (s.func == FUNC_ENTRY) begin
				entries[s.addr] = {s.entry_kind, s.entry_target};
			end else if (s.func == FUNC_MOVE) begin
				moves[s.addr] = {s.angle_c, s.angle_b, s.angle_a, s.move_speed, s.move_time};
			end else if (s.func == FUNC_TICK && s.now > exit_time) begin
				lv = depth;
				where = level_base[lv] + level_pos[lv];
				if (level_sub[lv]) begin
					e = entries[where];
					if (e.kind >= KIND_END) begin
						climb();
					end else if (lv < LEVELS - 1) begin
						depth = lv + 1;
						level_sub[lv + 1] = (e.kind == KIND_SUB);
						level_base[lv + 1] = e.target;
						level_pos[lv + 1] = '0;
					end else begin
						// no room for a child at the deepest level, step over it
						level_pos[lv] = level_pos[lv] + 8'd1;
					end
				end else begin
					m = moves[where];
					if (m.time_u[10]) begin
						climb();
					end else begin
						expected_moves.push_back('{angle_a: m.angle_a, angle_b: m.angle_b,
							angle_c: m.angle_c, speed: m.speed});
						exit_time = s.now + 32'(m.time_u[9:0]) * 32'(units);
						level_pos[lv] = level_pos[lv] + 8'd1;
					end
				end
			end
		endfunction

		function void check_move(result_t got);
			result_t want;
			if (expected_moves.size() == 0) begin
				$error("move beat with nothing expected: a %0d b %0d c %0d speed %0d",
					got.angle_a, got.angle_b, got.angle_c, got.speed);
				errors++;
				return;
			end
			want = expected_moves.pop_front();
			if (got.angle_a !== want.angle_a) begin
				$error("out_angle_a expected %0d got %0d", want.angle_a, got.angle_a);
				errors++;
			end
			if (got.angle_b !== want.angle_b) begin
				$error("out_angle_b expected %0d got %0d", want.angle_b, got.angle_b);
				errors++;
			end
			if (got.angle_c !== want.angle_c) begin
				$error("out_angle_c expected %0d got %0d", want.angle_c, got.angle_c);
				errors++;
			end
			if (got.speed !== want.speed) begin
				$error("out_speed expected %0d got %0d", want.speed, got.speed);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic [7:0]         addr;
	logic [1:0]         entry_kind;
	logic [7:0]         entry_target;
	logic signed [10:0] move_time;
	logic [7:0]         move_speed;
	logic signed [8:0]  angle_a;
	logic signed [8:0]  angle_b;
	logic signed [8:0]  angle_c;
	logic [31:0]        now;
	logic               out_valid;
	logic               out_stall;
	logic signed [8:0]  out_angle_a;
	logic signed [8:0]  out_angle_b;
	logic signed [8:0]  out_angle_c;
	logic [7:0]         out_speed;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [15:0]        ticks_per_unit;

	move_scoreboard sb = new();
	int send_idle;
	int recv_idle;
	int stuck = 0;

	nested_motion_sequencer_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.addr(addr),
		.entry_kind(entry_kind),
		.entry_target(entry_target),
		.move_time(move_time),
		.move_speed(move_speed),
		.angle_a(angle_a),
		.angle_b(angle_b),
		.angle_c(angle_c),
		.now(now),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_angle_a(out_angle_a),
		.out_angle_b(out_angle_b),
		.out_angle_c(out_angle_c),
		.out_speed(out_speed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.ticks_per_unit(ticks_per_unit)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	// outputs only change at rising edges, so the beat seen here is the one taken next edge
	always @(negedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_move('{angle_a: out_angle_a, angle_b: out_angle_b,
				angle_c: out_angle_c, speed: out_speed});
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	function automatic logic signed [8:0] rand_angle();
		if ($urandom_range(0, 9) == 0)
			return 9'($urandom);
		return 9'(int'($urandom_range(0, 360)) - 180);
	endfunction

	function automatic stim_t noise();
		stim_t s;
		s.func = 2'($urandom);
		s.addr = 8'($urandom);
		s.entry_kind = 2'($urandom);
		s.entry_target = 8'($urandom);
		s.move_time = 11'($urandom);
		s.move_speed = 8'($urandom);
		s.angle_a = 9'($urandom);
		s.angle_b = 9'($urandom);
		s.angle_c = 9'($urandom);
		s.now = $urandom;
		return s;
	endfunction

	// biased towards nesting so the stack fills now and then
	function automatic stim_t rand_entry(input logic [7:0] a);
		stim_t s;
		int unsigned r;
		s = noise();
		s.func = FUNC_ENTRY;
		s.addr = a;
		r = $urandom_range(0, 99);
		if (r < 40)
			s.entry_kind = KIND_SUB;
		else if (r < 70)
			s.entry_kind = KIND_MOVES;
		else if (r < 95)
			s.entry_kind = KIND_END;
		else
			s.entry_kind = KIND_SPARE;
		return s;
	endfunction

	function automatic stim_t rand_move(input logic [7:0] a);
		stim_t s;
		int unsigned r;
		s = noise();
		s.func = FUNC_MOVE;
		s.addr = a;
		r = $urandom_range(0, 99);
		if (r < 20)
			s.move_time = {1'b1, 10'($urandom)};
		else if (r < 85)
			s.move_time = 11'($urandom_range(0, 3));
		else
			s.move_time = 11'($urandom_range(0, 1023));
		s.angle_a = rand_angle();
		s.angle_b = rand_angle();
		s.angle_c = rand_angle();
		return s;
	endfunction

	function automatic stim_t rand_tick();
		stim_t s;
		int unsigned r;
		s = noise();
		s.func = FUNC_TICK;
		r = $urandom_range(0, 99);
		if (r < 70)
			s.now = sb.exit_time + 32'($urandom_range(1, 40));
		else if (r < 80)
			s.now = sb.exit_time;
		else if (r < 88)
			s.now = sb.exit_time - 32'($urandom_range(1, 1000));
		else
			s.now = $urandom;
		return s;
	endfunction

	function automatic stim_t rand_item();
		stim_t s;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			s = noise();
			s.func = FUNC_NONE;
		end else if (r < 12) begin
			s = rand_entry(8'($urandom));
		end else if (r < 22) begin
			s = rand_move(8'($urandom));
		end else begin
			s = rand_tick();
		end
		return s;
	endfunction

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle = 23;
				recv_idle = 80;
			end
			1: begin
				send_idle = 80;
				recv_idle = 23;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
		endcase
	endtask

	task automatic drive_item(input stim_t s);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= s.func;
		addr <= s.addr;
		entry_kind <= s.entry_kind;
		entry_target <= s.entry_target;
		move_time <= s.move_time;
		move_speed <= s.move_speed;
		angle_a <= s.angle_a;
		angle_b <= s.angle_b;
		angle_c <= s.angle_c;
		now <= s.now;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(s);
	endtask

	task automatic write_entry(input logic [7:0] a, input logic [1:0] k, input logic [7:0] t);
		stim_t s;
		s = noise();
		s.func = FUNC_ENTRY;
		s.addr = a;
		s.entry_kind = k;
		s.entry_target = t;
		drive_item(s);
	endtask

	task automatic write_move(input logic [7:0] a, input logic signed [10:0] t,
		input logic [7:0] spd, input logic signed [8:0] pa, input logic signed [8:0] pb,
		input logic signed [8:0] pc);
		stim_t s;
		s = noise();
		s.func = FUNC_MOVE;
		s.addr = a;
		s.move_time = t;
		s.move_speed = spd;
		s.angle_a = pa;
		s.angle_b = pb;
		s.angle_c = pc;
		drive_item(s);
	endtask

	task automatic send_tick(input logic [31:0] t);
		stim_t s;
		s = noise();
		s.func = FUNC_TICK;
		s.now = t;
		drive_item(s);
	endtask

	// hold the sender until every move has come out and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_moves.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_units(input logic [15:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		ticks_per_unit <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.units = v;
	endtask

	initial begin
		stim_t s;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_TICK;
		addr = '0;
		entry_kind = KIND_MOVES;
		entry_target = '0;
		move_time = '0;
		move_speed = '0;
		angle_a = '0;
		angle_b = '0;
		angle_c = '0;
		now = '0;
		cfg_valid = 1'b0;
		ticks_per_unit = TPU_RESET;
		set_idling(0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// every word of both tables is written before play can read it
		for (int i = 0; i < 256; i++) begin
			drive_item(rand_entry(8'(i)));
			drive_item(rand_move(8'(i)));
		end

		// a chain four levels deep, a child skipped at the full stack, kind three,
		// wide angles, a move table wrapping past its end and a root restart
		write_entry(8'd0, KIND_SUB, 8'd16);
		write_entry(8'd16, KIND_SUB, 8'd32);
		write_entry(8'd32, KIND_SUB, 8'd48);
		write_entry(8'd48, KIND_SUB, 8'd64);
		write_entry(8'd64, KIND_SUB, 8'd80);
		write_entry(8'd65, KIND_SPARE, 8'd0);
		write_entry(8'd49, KIND_MOVES, 8'd250);
		write_entry(8'd50, KIND_END, 8'd255);
		write_entry(8'd33, KIND_END, 8'd0);
		write_entry(8'd17, KIND_END, 8'd0);
		write_entry(8'd1, KIND_MOVES, 8'd254);
		write_entry(8'd2, KIND_END, 8'd0);
		write_move(8'd250, 11'sd1023, 8'd255, 9'sd180, -9'sd180, 9'h100);
		write_move(8'd251, 11'sd0, 8'd0, -9'sd180, 9'h0FF, 9'h1FF);
		write_move(8'd252, 11'h7FF, 8'd7, 9'sd1, 9'sd2, 9'sd3);
		write_move(8'd254, 11'sd2, 8'd128, 9'sd0, 9'sd90, -9'sd90);
		write_move(8'd255, 11'sd1, 8'd1, 9'sd45, -9'sd45, 9'sd0);
		write_move(8'd0, 11'h400, 8'd0, 9'sd0, 9'sd0, 9'sd0);
		s = noise();
		s.func = FUNC_NONE;
		drive_item(s);
		repeat (8) send_tick(sb.exit_time + 32'd1);
		// equal and earlier times must not step
		send_tick(sb.exit_time);
		send_tick(sb.exit_time - 32'd5);
		repeat (6) send_tick(sb.exit_time + 32'd1);
		// the exit time wraps past the top of the counter here
		send_tick(32'hFFFF_FFFF);
		repeat (4) send_tick(sb.exit_time + 32'd1);

		for (int p = 0; p < 6; p++) begin
			set_idling(p / 2);
			case (p)
				0: set_units(16'd1);
				1: set_units(16'hFFFF);
				2: set_units(16'd0);
				5: set_units(TPU_RESET);
				default: set_units(16'($urandom_range(2, 65534)));
			endcase
			repeat (PHASE_ITEMS) drive_item(rand_item());
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_moves.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
